// ===== rtl/websocket_frame_deframer_top_assert.svh =====
// Assertion macros shared by the checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication.
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_EXT16,
    PH_EXT64,
    PH_MASK,
    PH_PAYLOAD
  } wsd_phase_e;

  // Opcode values matched on the low seven bits
  localparam logic [6:0] OPC_CONT   = 7'h00;
  localparam logic [6:0] OPC_TEXT   = 7'h01;
  localparam logic [6:0] OPC_BINARY = 7'h02;

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] MASK_LAST  = 3'd3;

  typedef struct packed {
    logic empty_frame;
    logic last_byte;
  } wsd_flags_t;

endpackage

// ===== rtl/wsd_front.sv =====
// Header parser: hunts for an opcode, decodes length and mask key, and tags
// each payload byte with its key byte.
module wsd_front #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [7:0]              rx_byte_i,
  input  logic                    expect_start_i,
  output logic                    wr_o,
  output logic [7:0]              data_o,
  output logic [7:0]              key_o,
  output logic [7:0]              opcode_o,
  output logic [LENGTH_WIDTH-1:0] len_o,
  output wsd_pkg::wsd_flags_t     flags_o
);

  localparam int LW = LENGTH_WIDTH;

  wsd_pkg::wsd_phase_e phase_q, phase_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic [LW-1:0] left_q, left_d;
  logic [31:0]   key_q, key_d;
  logic [1:0]    kidx_q, kidx_d;
  logic          masked_q, masked_d;
  logic [7:0]    opc_q, opc_d;

  logic [6:0]    low7;
  logic          hunt_hit;
  logic          is_len, is_ext, len_short, ext_end, mask_end;
  logic [LW+7:0] shifted;
  logic [LW-1:0] ext_val, len_sat, known_val, begin_len;
  logic          ext_ovf, len_known, known_mask, begin_pay, hdr_empty, pay_last;
  logic          is_pay;

  // Header decode conditions
  always_comb begin
    low7      = rx_byte_i[6:0];
    hunt_hit  = expect_start_i ? (low7 inside {wsd_pkg::OPC_TEXT, wsd_pkg::OPC_BINARY})
                               : (low7 == wsd_pkg::OPC_CONT);
    is_len    = (phase_q == wsd_pkg::PH_LEN);
    is_ext    = (phase_q == wsd_pkg::PH_EXT16) || (phase_q == wsd_pkg::PH_EXT64);
    is_pay    = (phase_q == wsd_pkg::PH_PAYLOAD);
    len_short = is_len && !(low7 inside {wsd_pkg::LEN_EXT16, wsd_pkg::LEN_EXT64});
    ext_end   = ((phase_q == wsd_pkg::PH_EXT16) && (cnt_q == wsd_pkg::EXT16_LAST)) ||
                ((phase_q == wsd_pkg::PH_EXT64) && (cnt_q == wsd_pkg::EXT64_LAST));
    mask_end  = (phase_q == wsd_pkg::PH_MASK) && (cnt_q == wsd_pkg::MASK_LAST);
    shifted   = {len_q, rx_byte_i};
    ext_val   = shifted[LW-1:0];
    ext_ovf   = ovf_q | (|shifted[LW+7:LW]);
    len_sat   = ext_ovf ? {LW{1'b1}} : ext_val;
    len_known = len_short | (is_ext & ext_end);
    known_val = is_len ? LW'(low7) : len_sat;
    known_mask = is_len ? rx_byte_i[7] : masked_q;
    begin_pay = (len_known & ~known_mask) | mask_end;
    begin_len = mask_end ? len_q : known_val;
    hdr_empty = begin_pay && (begin_len == '0);
    pay_last  = is_pay && (left_q == LW'(1));
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    if (in_valid_i) begin
      case (phase_q)
        wsd_pkg::PH_HUNT: begin
          phase_d = hunt_hit ? wsd_pkg::PH_LEN : wsd_pkg::PH_HUNT;
        end
        wsd_pkg::PH_LEN: begin
          if (low7 == wsd_pkg::LEN_EXT16) begin
            phase_d = wsd_pkg::PH_EXT16;
          end else if (low7 == wsd_pkg::LEN_EXT64) begin
            phase_d = wsd_pkg::PH_EXT64;
          end else if (known_mask) begin
            phase_d = wsd_pkg::PH_MASK;
          end else begin
            phase_d = hdr_empty ? wsd_pkg::PH_HUNT : wsd_pkg::PH_PAYLOAD;
          end
        end
        wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
          if (ext_end) begin
            if (masked_q) begin
              phase_d = wsd_pkg::PH_MASK;
            end else begin
              phase_d = hdr_empty ? wsd_pkg::PH_HUNT : wsd_pkg::PH_PAYLOAD;
            end
          end
        end
        wsd_pkg::PH_MASK: begin
          if (mask_end) begin
            phase_d = hdr_empty ? wsd_pkg::PH_HUNT : wsd_pkg::PH_PAYLOAD;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          if (pay_last) begin
            phase_d = wsd_pkg::PH_HUNT;
          end
        end
        default: phase_d = wsd_pkg::PH_HUNT;
      endcase
    end
  end

  // Result outputs
  always_comb begin
    wr_o                  = in_valid_i & (hdr_empty | is_pay);
    data_o                = is_pay ? rx_byte_i : 8'h00;
    key_o                 = is_pay ? key_q[{~kidx_q, 3'b000} +: 8] : 8'h00;
    opcode_o              = opc_q;
    len_o                 = is_pay ? len_q : begin_len;
    flags_o.empty_frame   = ~is_pay;
    flags_o.last_byte     = ~is_pay | pay_last;
  end

  // Datapath next values
  always_comb begin
    cnt_d    = cnt_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    left_d   = left_q;
    key_d    = key_q;
    kidx_d   = kidx_q;
    masked_d = masked_q;
    opc_d    = opc_q;
    if (in_valid_i) begin
      case (phase_q)
        wsd_pkg::PH_HUNT: begin
          if (hunt_hit) begin
            opc_d = rx_byte_i;
          end
        end
        wsd_pkg::PH_LEN: begin
          masked_d = rx_byte_i[7];
          key_d    = '0;
          cnt_d    = '0;
          ovf_d    = 1'b0;
          len_d    = len_short ? LW'(low7) : '0;
        end
        wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
          ovf_d = ext_ovf;
          if (ext_end) begin
            len_d = len_sat;
            cnt_d = '0;
          end else begin
            len_d = ext_val;
            cnt_d = cnt_q + 3'd1;
          end
        end
        wsd_pkg::PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = mask_end ? 3'd0 : cnt_q + 3'd1;
        end
        wsd_pkg::PH_PAYLOAD: begin
          kidx_d = kidx_q + 2'd1;
          left_d = left_q - LW'(1);
        end
        default: ;
      endcase
      if (begin_pay) begin
        left_d = begin_len;
        kidx_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsd_pkg::PH_HUNT;
      cnt_q    <= '0;
      len_q    <= '0;
      ovf_q    <= 1'b0;
      left_q   <= '0;
      key_q    <= '0;
      kidx_q   <= '0;
      masked_q <= 1'b0;
      opc_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      left_q   <= left_d;
      key_q    <= key_d;
      kidx_q   <= kidx_d;
      masked_q <= masked_d;
      opc_q    <= opc_d;
    end
  end

endmodule

// ===== rtl/wsd_fifo.sv =====
// Short queue between the parser and the output stage.
module wsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/wsd_back.sv =====
// Output stage: unmasks the payload byte and holds the result for pop.
module wsd_back #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  logic [7:0]              q_data_i,
  input  logic [7:0]              q_key_i,
  input  logic [7:0]              q_opcode_i,
  input  logic [LENGTH_WIDTH-1:0] q_len_i,
  input  wsd_pkg::wsd_flags_t     q_flags_i,
  output logic                    q_rd_o,
  input  logic                    pop,
  output logic                    empty,
  output logic [7:0]              payload_byte_o,
  output logic [7:0]              frame_opcode_o,
  output logic [63:0]             payload_length_o,
  output logic                    empty_frame_o,
  output logic                    last_byte_o
);

  logic                    ov_q;
  logic [7:0]              byte_q, opc_q;
  logic [LENGTH_WIDTH-1:0] len_q;
  wsd_pkg::wsd_flags_t     flags_q;

  assign q_rd_o = ~q_empty_i & (~ov_q | pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (q_rd_o) begin
      ov_q <= 1'b1;
    end else if (pop) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      byte_q  <= q_data_i ^ q_key_i;
      opc_q   <= q_opcode_i;
      len_q   <= q_len_i;
      flags_q <= q_flags_i;
    end
  end

  assign empty            = ~ov_q;
  assign payload_byte_o   = byte_q;
  assign frame_opcode_o   = opc_q;
  assign payload_length_o = 64'(len_q);
  assign empty_frame_o    = flags_q.empty_frame;
  assign last_byte_o      = flags_q.last_byte;

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
// Channel | Dir | Handshake               | Beat
// --------+-----+-------------------------+-------------------------------------------
// rx      | in  | push / full             | rx_byte_i, expect_start_i
// result  | out | empty / pop             | payload_byte_o, frame_opcode_o,
//         |     |                         | payload_length_o, empty_frame_o, last_byte_o
//
// One received byte is taken per clock while full is low, so header and payload
// bytes stream at one beat per clock.
// A result reaches the output by way of parser -> queue -> output register.
// full rises only when the queue between parser and output stage is full,
// i.e. when pop has been held off for QUEUE_DEPTH + 1 results.
// Asynchronous active-low reset returns the parser to hunting and empties the queue.
module websocket_frame_deframer_top #(
  parameter int LENGTH_WIDTH = 64,  // stored length width, 16..64; longer lengths saturate
  parameter int QUEUE_DEPTH  = 4    // entries between parser and output stage, >= 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        expect_start_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  frame_opcode_o,
  output logic [63:0] payload_length_o,
  output logic        empty_frame_o,
  output logic        last_byte_o
);

  localparam int FW = $bits(wsd_pkg::wsd_flags_t);
  // queue entry: opcode, raw byte, key byte, length, flags
  localparam int EW = 24 + LENGTH_WIDTH + FW;

  logic                    in_acc;
  logic                    f_wr;
  logic [7:0]              f_data, f_key, f_opc;
  logic [LENGTH_WIDTH-1:0] f_len;
  wsd_pkg::wsd_flags_t     f_flags;

  logic [EW-1:0]           q_wdata, q_rdata;
  logic                    q_rd, q_empty;

  logic [7:0]              h_data, h_key, h_opc;
  logic [LENGTH_WIDTH-1:0] h_len;
  wsd_pkg::wsd_flags_t     h_flags;

  // Accepted input beat; the parser only advances on these.
  assign in_acc = push & ~full;

  wsd_front #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_acc),
    .rx_byte_i      (rx_byte_i),
    .expect_start_i (expect_start_i),
    .wr_o           (f_wr),
    .data_o         (f_data),
    .key_o          (f_key),
    .opcode_o       (f_opc),
    .len_o          (f_len),
    .flags_o        (f_flags)
  );

  assign q_wdata = {f_opc, f_data, f_key, f_len, f_flags};

  // Unmasking is deferred to the output stage; the queue carries the key byte.
  wsd_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_wr),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (q_empty)
  );

  assign {h_opc, h_data, h_key, h_len, h_flags} = q_rdata;

  wsd_back #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_data_i         (h_data),
    .q_key_i          (h_key),
    .q_opcode_i       (h_opc),
    .q_len_i          (h_len),
    .q_flags_i        (h_flags),
    .q_rd_o           (q_rd),
    .pop              (pop),
    .empty            (empty),
    .payload_byte_o   (payload_byte_o),
    .frame_opcode_o   (frame_opcode_o),
    .payload_length_o (payload_length_o),
    .empty_frame_o    (empty_frame_o),
    .last_byte_o      (last_byte_o)
  );

endmodule

// ===== rtl/wsd_checker.sv =====
`include "websocket_frame_deframer_top_assert.svh"

module wsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  payload_byte_o,
  input logic [7:0]  frame_opcode_o,
  input logic [63:0] payload_length_o,
  input logic        empty_frame_o,
  input logic        last_byte_o
);

  // A result that is not taken must stay put.
  `WSD_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(payload_byte_o) && $stable(payload_length_o) && $stable(last_byte_o), "result changed while stalled")

  // An empty frame is a single, final, zero beat.
  `WSD_ASSERT_NOW(a_empty_last, clk_i, rst_ni, !empty && empty_frame_o, last_byte_o && (payload_byte_o == 8'h00), "empty frame beat malformed")

  // Zero length and the empty flag go together.
  `WSD_ASSERT_NOW(a_len_zero, clk_i, rst_ni, !empty, empty_frame_o == (payload_length_o == 64'd0), "length and empty flag disagree")

  // Only data or continuation opcodes start a frame.
  `WSD_ASSERT_NOW(a_opcode, clk_i, rst_ni, !empty, (frame_opcode_o[6:0] == 7'h00) || (frame_opcode_o[6:0] == 7'h01) || (frame_opcode_o[6:0] == 7'h02), "unexpected frame opcode")

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .payload_byte_o   (payload_byte_o),
  .frame_opcode_o   (frame_opcode_o),
  .payload_length_o (payload_length_o),
  .empty_frame_o    (empty_frame_o),
  .last_byte_o      (last_byte_o)
);

// ===== sim/tb.sv =====
module tb;

  // Stored length width; must match the DUT parameter below.
  localparam int          LEN_W     = 64;
  localparam logic [63:0] LEN_MAX   = (LEN_W >= 64) ? '1 : ((64'd1 << LEN_W) - 64'd1);
  localparam int          WD_LIMIT  = 1000;  // idle cycles before the run is abandoned
  localparam int          RAND_BEATS = 800;  // framed bytes in the random part
  localparam int          NUM_DIR   = 24;
  localparam int          NUM_TAIL  = 17;

  // One result beat as the DUT presents it.
  typedef struct packed {
    logic [7:0]  payload;
    logic [7:0]  opcode;
    logic [63:0] len;
    logic        is_empty;
    logic        is_last;
  } frame_beat_t;

  // One stimulus row; want is only used when typed is set.
  typedef struct packed {
    logic [7:0]  rx;
    logic        start;
    logic        typed;
    frame_beat_t want;
  } stim_row_t;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_COIN,
    POP_STALLS,
    POP_SPARSE
  } pop_mode_e;

  localparam frame_beat_t NO_BEAT = '0;
  localparam logic [63:0] ALL_ONES = '1;

  // Directed rows: opcode filtering, empty frames (plain and masked),
  // a non-minimal 16-bit length with a mask key, a one-byte frame.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIR] = '{
    '{8'h00, 1'b1, 1'b0, NO_BEAT},                          // continuation when start wanted
    '{8'h01, 1'b0, 1'b0, NO_BEAT},                          // text when continuation wanted
    '{8'hF2, 1'b1, 1'b0, NO_BEAT},                          // upper bits spoil the match
    '{8'h81, 1'b1, 1'b0, NO_BEAT},                          // FIN text
    '{8'h00, 1'b0, 1'b1, '{8'h00, 8'h81, 64'd0, 1'b1, 1'b1}}, // plain empty frame
    '{8'h82, 1'b1, 1'b0, NO_BEAT},                          // FIN binary
    '{8'h80, 1'b0, 1'b0, NO_BEAT},                          // masked, length 0
    '{8'hDE, 1'b0, 1'b0, NO_BEAT},
    '{8'hAD, 1'b1, 1'b0, NO_BEAT},
    '{8'hBE, 1'b0, 1'b0, NO_BEAT},
    '{8'hEF, 1'b1, 1'b1, '{8'h00, 8'h82, 64'd0, 1'b1, 1'b1}}, // key eaten, then empty
    '{8'h00, 1'b0, 1'b0, NO_BEAT},                          // continuation
    '{8'hFE, 1'b0, 1'b0, NO_BEAT},                          // masked, 16-bit length
    '{8'h00, 1'b0, 1'b0, NO_BEAT},
    '{8'h02, 1'b0, 1'b0, NO_BEAT},                          // non-minimal length 2
    '{8'hFF, 1'b0, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, 1'b0, NO_BEAT},
    '{8'hA5, 1'b0, 1'b0, NO_BEAT},
    '{8'h5A, 1'b0, 1'b0, NO_BEAT},
    '{8'h0F, 1'b1, 1'b1, '{8'hF0, 8'h00, 64'd2, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, 8'h00, 64'd2, 1'b0, 1'b1}},
    '{8'h80, 1'b0, 1'b0, NO_BEAT},                          // FIN continuation
    '{8'h01, 1'b0, 1'b0, NO_BEAT},                          // plain, length 1
    '{8'h55, 1'b1, 1'b1, '{8'h55, 8'h80, 64'd1, 1'b0, 1'b1}}
  };

  // Tail rows: masked frame with the widest 64-bit length. Its payload never
  // ends, so it goes last.
  localparam stim_row_t TAIL_ROWS [NUM_TAIL] = '{
    '{8'h82, 1'b1, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b1, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b1, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b1, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b1, 1'b0, NO_BEAT},
    '{8'h01, 1'b0, 1'b0, NO_BEAT},
    '{8'h02, 1'b0, 1'b0, NO_BEAT},
    '{8'h03, 1'b0, 1'b0, NO_BEAT},
    '{8'h04, 1'b0, 1'b0, NO_BEAT},
    '{8'h10, 1'b0, 1'b1, '{8'h11, 8'h82, ALL_ONES, 1'b0, 1'b0}},
    '{8'h20, 1'b1, 1'b1, '{8'h22, 8'h82, ALL_ONES, 1'b0, 1'b0}},
    '{8'h30, 1'b0, 1'b1, '{8'h33, 8'h82, ALL_ONES, 1'b0, 1'b0}}
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [7:0]  rx_byte_i      = 8'h00;
  logic        expect_start_i = 1'b0;
  logic        empty;
  logic        pop            = 1'b0;
  logic [7:0]  payload_byte_o;
  logic [7:0]  frame_opcode_o;
  logic [63:0] payload_length_o;
  logic        empty_frame_o;
  logic        last_byte_o;

  // Travel with each beat so the checker sees them on the same edge as the DUT.
  logic        beat_typed = 1'b0;
  frame_beat_t beat_want  = '0;

  websocket_frame_deframer_top #(
    .LENGTH_WIDTH(LEN_W)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte_i),
    .expect_start_i   (expect_start_i),
    .empty            (empty),
    .pop              (pop),
    .payload_byte_o   (payload_byte_o),
    .frame_opcode_o   (frame_opcode_o),
    .payload_length_o (payload_length_o),
    .empty_frame_o    (empty_frame_o),
    .last_byte_o      (last_byte_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Deframer prediction: own copy of the parser state.
  // ---------------------------------------------------------------------
  wsd_pkg::wsd_phase_e parse_phase  = wsd_pkg::PH_HUNT;
  logic [2:0]  hdr_cnt      = '0;
  logic [63:0] frame_len    = '0;
  logic [63:0] bytes_due    = '0;
  logic [31:0] key_word     = '0;
  logic [1:0]  key_pos      = '0;
  logic        masked_frame = 1'b0;
  logic [7:0]  frame_op     = '0;

  frame_beat_t expected_beats [$];
  int          mismatches  = 0;
  int          idle_cycles = 0;

  // Advance the parser by one byte; returns 1 when a result beat is due.
  function automatic bit predict_byte(input logic [7:0] b, input logic start,
                                      output frame_beat_t res);
    logic [6:0] low7;
    logic [7:0] key_b;
    bit         len_known;
    bit         hdr_done;
    bit         got;
    low7      = b[6:0];
    len_known = 1'b0;
    hdr_done  = 1'b0;
    got       = 1'b0;
    res       = '0;
    case (parse_phase)
      wsd_pkg::PH_LEN: begin
        masked_frame = b[7];
        key_word     = '0;
        hdr_cnt      = '0;
        frame_len    = '0;
        if (low7 == wsd_pkg::LEN_EXT16) begin
          parse_phase = wsd_pkg::PH_EXT16;
        end else if (low7 == wsd_pkg::LEN_EXT64) begin
          parse_phase = wsd_pkg::PH_EXT64;
        end else begin
          frame_len = 64'(low7);
          len_known = 1'b1;
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        frame_len = {frame_len[55:0], b};
        hdr_cnt   = hdr_cnt + 3'd1;  // wraps to 0 after the eighth 64-bit byte
        if (hdr_cnt == ((parse_phase == wsd_pkg::PH_EXT16) ? 3'd2 : 3'd0))
          len_known = 1'b1;
      end
      wsd_pkg::PH_MASK: begin
        key_word = {key_word[23:0], b};
        hdr_cnt  = hdr_cnt + 3'd1;
        if (hdr_cnt >= 3'd4) begin
          hdr_cnt  = '0;
          hdr_done = 1'b1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        key_b     = key_word[8 * (3 - int'(key_pos)) +: 8];
        key_pos   = key_pos + 2'd1;
        bytes_due = bytes_due - 64'd1;
        res       = '{b ^ key_b, frame_op, frame_len, 1'b0, bytes_due == 64'd0};
        got       = 1'b1;
        if (bytes_due == 64'd0) parse_phase = wsd_pkg::PH_HUNT;
      end
      default: begin
        parse_phase = wsd_pkg::PH_HUNT;
        if ((start && (low7 == wsd_pkg::OPC_TEXT || low7 == wsd_pkg::OPC_BINARY)) ||
            (!start && low7 == wsd_pkg::OPC_CONT)) begin
          frame_op    = b;
          parse_phase = wsd_pkg::PH_LEN;
        end
      end
    endcase
    if (len_known) begin
      if (frame_len > LEN_MAX) frame_len = LEN_MAX;
      if (masked_frame) begin
        hdr_cnt     = '0;
        parse_phase = wsd_pkg::PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end
    if (hdr_done) begin
      if (frame_len == 64'd0) begin
        // empty frame: one flagged beat, straight back to hunting
        res         = '{8'h00, frame_op, frame_len, 1'b1, 1'b1};
        got         = 1'b1;
        parse_phase = wsd_pkg::PH_HUNT;
      end else begin
        bytes_due   = frame_len;
        key_pos     = '0;
        parse_phase = wsd_pkg::PH_PAYLOAD;
      end
    end
    return got;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 200)
      $display("mismatch %s: got %h want %h (t=%0t)", field, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------------
  // Checker: output beats against the oldest expectation, then input beats
  // through the predictor. Both sampled on the same edge as the DUT.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    frame_beat_t want;
    frame_beat_t pred;
    if (pop && !empty) begin
      if (expected_beats.size() == 0) begin
        note_mismatch("unexpected beat", {payload_byte_o, frame_opcode_o, 48'h0}, '0);
      end else begin
        want = expected_beats.pop_front();
        if (payload_byte_o !== want.payload)
          note_mismatch("payload_byte", 64'(payload_byte_o), 64'(want.payload));
        if (frame_opcode_o !== want.opcode)
          note_mismatch("frame_opcode", 64'(frame_opcode_o), 64'(want.opcode));
        if (payload_length_o !== want.len)
          note_mismatch("payload_length", payload_length_o, want.len);
        if (empty_frame_o !== want.is_empty)
          note_mismatch("empty_frame", 64'(empty_frame_o), 64'(want.is_empty));
        if (last_byte_o !== want.is_last)
          note_mismatch("last_byte", 64'(last_byte_o), 64'(want.is_last));
      end
    end
    if (push && !full) begin
      if (predict_byte(rx_byte_i, expect_start_i, pred))
        expected_beats.push_back(beat_typed ? beat_want : pred);
    end
    // watchdog: any handshake resets it
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: pop pattern switches between randomly chosen modes.
  // ---------------------------------------------------------------------
  pop_mode_e pop_mode   = POP_ALWAYS;
  int        mode_left  = 0;
  int        stall_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (mode_left == 0) begin
        pop_mode  = pop_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        POP_STALLS: begin
          if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(2, 16);
          end
        end
        default:    pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sender: bursts of random length, gaps of random length between them.
  // ---------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_beat(input stim_row_t row);
    if (burst_left == 0) begin
      push <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 20)) @(posedge clk_i);
      else repeat ($urandom_range(1, 4)) @(posedge clk_i);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    if (!push) push <= 1'b1;
    rx_byte_i      <= row.rx;
    expect_start_i <= row.start;
    beat_typed     <= row.typed;
    beat_want      <= row.want;
    do @(posedge clk_i); while (full);
  endtask

  // Hold the sender off until every expected beat has come out.
  task automatic drain_hold;
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
  endtask

  initial begin
    stim_row_t   frame_rows [$];
    stim_row_t   row;
    logic [63:0] flen;
    logic        masked;
    int          pick;
    int          framed;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) send_beat(DIRECTED_ROWS[i]);
    drain_hold();

    // Random part: well-formed frames with random content, separated by
    // bytes the hunter must skip. Lengths stay small so frames finish.
    framed = 0;
    while (framed < RAND_BEATS) begin
      frame_rows.delete();
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
        row = '0;
        row.rx = 8'($urandom_range(0, 255));
        // pick the start flag that does not match this byte
        if (row.rx[6:0] == wsd_pkg::OPC_TEXT || row.rx[6:0] == wsd_pkg::OPC_BINARY)
          row.start = 1'b0;
        else if (row.rx[6:0] == wsd_pkg::OPC_CONT) row.start = 1'b1;
        else row.start = 1'($urandom_range(0, 1));
        frame_rows.push_back(row);
      end
      pick = $urandom_range(0, 2);
      row = '0;
      row.rx    = {1'($urandom_range(0, 1)),
                   (pick == 0) ? wsd_pkg::OPC_CONT :
                   (pick == 1) ? wsd_pkg::OPC_TEXT : wsd_pkg::OPC_BINARY};
      row.start = (pick != 0);
      frame_rows.push_back(row);
      masked = 1'($urandom_range(0, 1));
      pick   = $urandom_range(0, 99);
      row = '0;
      row.start = 1'($urandom_range(0, 1));
      if (pick < 70) begin
        flen   = (pick < 55) ? 64'($urandom_range(0, 8)) : 64'($urandom_range(9, 125));
        row.rx = {masked, flen[6:0]};
        frame_rows.push_back(row);
      end else if (pick < 85) begin
        flen   = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(126, 600))
                                             : 64'($urandom_range(0, 40));
        row.rx = {masked, wsd_pkg::LEN_EXT16};
        frame_rows.push_back(row);
        for (int k = 1; k >= 0; k--) begin
          row.rx = flen[8 * k +: 8];
          frame_rows.push_back(row);
        end
      end else begin
        flen   = 64'($urandom_range(0, 40));
        row.rx = {masked, wsd_pkg::LEN_EXT64};
        frame_rows.push_back(row);
        for (int k = 7; k >= 0; k--) begin
          row.rx = flen[8 * k +: 8];
          frame_rows.push_back(row);
        end
      end
      if (masked) begin
        repeat (4) begin
          row.rx    = 8'($urandom_range(0, 255));
          row.start = 1'($urandom_range(0, 1));
          frame_rows.push_back(row);
        end
      end
      for (int k = 0; k < int'(flen); k++) begin
        row.rx    = 8'($urandom_range(0, 255));
        row.start = 1'($urandom_range(0, 1));
        frame_rows.push_back(row);
      end
      foreach (frame_rows[k]) send_beat(frame_rows[k]);
      framed += frame_rows.size();
    end
    drain_hold();

    for (int i = 0; i < NUM_TAIL; i++) send_beat(TAIL_ROWS[i]);
    push <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
    // allow a stray late beat to show itself
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
